/* hw/rtl/tix_section_pattern_shuffle_macros.svh */
// Assertion helpers for the section pattern shuffle block.
`ifndef TIX_SECTION_PATTERN_SHUFFLE_MACROS_SVH
`define TIX_SECTION_PATTERN_SHUFFLE_MACROS_SVH

`ifndef SYNTH
// Consequent checked in the same cycle as the antecedent.
`define TSPS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsps: assertion failed");
// Consequent checked in the cycle after the antecedent.
`define TSPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsps: assertion failed");
`else
`define TSPS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TSPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/tsps_pkg.sv */
package tsps_pkg;

  localparam int SEC_W    = 2;
  localparam int CNT_W    = 4;
  localparam int BYTE_W   = 8;
  localparam int LED_W    = 5;
  localparam int OUT_CW   = 3;   // color width kept in state and on the output
  localparam int CLR_W    = 4;   // internal color, holds up to a 16 entry palette
  localparam int DIV_W    = 5;   // divisor of the remainder unit, up to 16
  localparam int NUM_RAND = 8;
  localparam int LIST_DEPTH = 9;
  localparam int LIST_AW  = $clog2(LIST_DEPTH);
  localparam int NUM_SEC  = 4;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 16;

  typedef struct packed {
    logic load;       // capture a request
    logic mod_start;  // start the remainder unit
    logic mod_sel;    // 0: color byte, 1: shuffle byte
    logic color_set;  // take the color remainder
    logic pass_step;  // one step of the color conflict pass
    logic j_set;      // take the swap index remainder
    logic swap_rd;    // read list entries i and j
    logic wr_i;       // write entry i
    logic wr_j;       // write entry j and step i down
    logic out_rd;     // read list entry k
    logic out_load;   // load the output register
    logic out_take;   // output result taken downstream
  } tsps_cmd_t;

  typedef struct packed {
    logic too_big;
    logic mod_done;
    logic pass_last;
    logic step_last;
    logic out_last;
  } tsps_stat_t;

  function automatic logic [CNT_W-1:0] sec_size(input logic [SEC_W-1:0] sec);
    logic [CNT_W-1:0] s;
    unique case (sec)
      2'd0:    s = 4'd9;
      2'd1:    s = 4'd6;
      2'd2:    s = 4'd9;
      default: s = 4'd3;
    endcase
    return s;
  endfunction

  function automatic logic [LED_W-1:0] sec_base(input logic [SEC_W-1:0] sec);
    logic [LED_W-1:0] b;
    unique case (sec)
      2'd0:    b = 5'd0;
      2'd1:    b = 5'd9;
      2'd2:    b = 5'd15;
      default: b = 5'd24;
    endcase
    return b;
  endfunction

endpackage

/* hw/rtl/tsps_mod.sv */
module tsps_mod
  import tsps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [BYTE_W-1:0]   dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic                done,
  output logic [CLR_W-1:0]    rem
);

  localparam int BITS_PER_CYC = 4;

  logic              busy;
  logic              phase;
  logic [BYTE_W-1:0] shreg;
  logic [CLR_W-1:0]  part;
  logic [CLR_W-1:0]  part_next;

  // Restoring remainder, four dividend bits per cycle. The partial value
  // stays below the divisor, so it fits in four bits between steps.
  always_comb begin
    logic [DIV_W-1:0] v;
    part_next = part;
    for (int b = 0; b < BITS_PER_CYC; b++) begin
      v = {part_next, shreg[BYTE_W-1-b]};
      if (v >= divisor) begin
        v = v - divisor;
      end
      part_next = v[CLR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
      end else if (busy) begin
        phase <= ~phase;
        if (phase) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      part  <= '0;
    end else if (busy) begin
      shreg <= shreg << BITS_PER_CYC;
      part  <= part_next;
    end
  end

  assign rem = part;

endmodule

/* hw/rtl/tsps_ctrl.sv */
module tsps_ctrl
  import tsps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       m_tready,
  input  tsps_stat_t stat,
  output tsps_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CMOD  = 4'd1;
  localparam logic [3:0] ST_CWAIT = 4'd2;
  localparam logic [3:0] ST_CPASS = 4'd3;
  localparam logic [3:0] ST_SMOD  = 4'd4;
  localparam logic [3:0] ST_SWAIT = 4'd5;
  localparam logic [3:0] ST_SRD   = 4'd6;
  localparam logic [3:0] ST_SWI   = 4'd7;
  localparam logic [3:0] ST_SWJ   = 4'd8;
  localparam logic [3:0] ST_ORD   = 4'd9;
  localparam logic [3:0] ST_OLD   = 4'd10;
  localparam logic [3:0] ST_OWAIT = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_tready = (state == ST_IDLE) && !rst;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_CMOD;
        end
      end
      ST_CMOD: begin
        // An oversized count gives no result and leaves the state alone.
        if (stat.too_big) begin
          state_next = ST_IDLE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        if (stat.mod_done) begin
          cmd.color_set = 1'b1;
          state_next    = ST_CPASS;
        end
      end
      ST_CPASS: begin
        cmd.pass_step = 1'b1;
        if (stat.pass_last) begin
          state_next = ST_SMOD;
        end
      end
      ST_SMOD: begin
        cmd.mod_start = 1'b1;
        cmd.mod_sel   = 1'b1;
        state_next    = ST_SWAIT;
      end
      ST_SWAIT: begin
        cmd.mod_sel = 1'b1;
        if (stat.mod_done) begin
          cmd.j_set  = 1'b1;
          state_next = ST_SRD;
        end
      end
      ST_SRD: begin
        cmd.swap_rd = 1'b1;
        state_next  = ST_SWI;
      end
      ST_SWI: begin
        cmd.wr_i   = 1'b1;
        state_next = ST_SWJ;
      end
      ST_SWJ: begin
        cmd.wr_j   = 1'b1;
        state_next = stat.step_last ? ST_ORD : ST_SMOD;
      end
      ST_ORD: begin
        cmd.out_rd = 1'b1;
        state_next = ST_OLD;
      end
      ST_OLD: begin
        cmd.out_load = 1'b1;
        state_next   = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (m_tready) begin
          cmd.out_take = 1'b1;
          state_next   = stat.out_last ? ST_IDLE : ST_ORD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/tsps_dp.sv */
`include "tix_section_pattern_shuffle_macros.svh"

module tsps_dp
  import tsps_pkg::*;
#(
  parameter int PALETTE_SIZE = 8
)
(
  input  logic             clk,
  input  logic             rst,
  input  tsps_cmd_t        cmd,
  output tsps_stat_t       stat,
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  localparam logic [DIV_W-1:0] COLOR_DIV = DIV_W'(PALETTE_SIZE);
  localparam int RAND_LSB = SEC_W + CNT_W + BYTE_W;

  logic [SEC_W-1:0]   sec;
  logic [CNT_W-1:0]   cnt;
  logic [BYTE_W-1:0]  crand;
  logic [BYTE_W-1:0]  rnd [NUM_RAND];
  logic [CLR_W-1:0]   color;
  logic [OUT_CW-1:0]  slc [NUM_SEC];
  logic [CNT_W-1:0]   k;
  logic [LIST_AW-1:0] i;
  logic [LIST_AW-1:0] j;
  logic [LIST_AW-1:0] mem [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] vld;
  logic [LIST_AW-1:0] rd_a;
  logic [LIST_AW-1:0] rd_b;
  logic               out_valid;
  logic [LED_W-1:0]   out_led;
  logic               out_lit;
  logic [OUT_CW-1:0]  out_color;
  logic               out_last;

  logic [CNT_W-1:0]   size;
  logic [LED_W-1:0]   base;
  logic [2:0]         ridx;
  logic [BYTE_W-1:0]  mod_dividend;
  logic [DIV_W-1:0]   mod_divisor;
  logic               mod_done;
  logic [CLR_W-1:0]   mod_rem;
  logic [LIST_AW-1:0] addr_a;
  logic               hit;
  logic [DIV_W-1:0]   color_inc;
  logic [CLR_W-1:0]   color_bumped;
  logic               k_is_last;

  assign size = sec_size(sec);
  assign base = sec_base(sec);

  // Step at index i uses the random byte number size - i, counted from one.
  assign ridx         = 3'(size - 4'd1 - i);
  assign mod_dividend = cmd.mod_sel ? rnd[ridx] : crand;
  assign mod_divisor  = cmd.mod_sel ? (DIV_W'(i) + 5'd1) : COLOR_DIV;

  tsps_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  assign hit          = (color[OUT_CW-1:0] == slc[k[SEC_W-1:0]]);
  assign color_inc    = DIV_W'(color) + 5'd1;
  assign color_bumped = (color_inc >= COLOR_DIV) ? '0 : color_inc[CLR_W-1:0];
  assign k_is_last    = (k == size - 4'd1);

  assign stat.too_big   = (cnt > size);
  assign stat.mod_done  = mod_done;
  assign stat.pass_last = (k[SEC_W-1:0] == sec);
  assign stat.step_last = (i == 4'd1);
  assign stat.out_last  = out_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sec   <= s_tdata[SEC_W-1:0];
      cnt   <= s_tdata[SEC_W +: CNT_W];
      crand <= s_tdata[SEC_W+CNT_W +: BYTE_W];
      for (int r = 0; r < NUM_RAND; r++) begin
        rnd[r] <= s_tdata[RAND_LSB + r*BYTE_W +: BYTE_W];
      end
    end
    if (cmd.color_set) begin
      color <= mod_rem;
      k     <= '0;
      i     <= LIST_AW'(size - 4'd1);
    end
    if (cmd.pass_step) begin
      if (hit) begin
        color <= color_bumped;
      end
      k <= stat.pass_last ? '0 : k + 4'd1;
    end
    if (cmd.j_set) begin
      j <= mod_rem;
    end
    if (cmd.wr_j) begin
      i <= i - 4'd1;
    end
    if (cmd.out_take) begin
      k <= k + 4'd1;
    end
    if (cmd.out_load) begin
      out_led   <= base + LED_W'(rd_a);
      out_lit   <= (k < cnt);
      out_color <= color[OUT_CW-1:0];
      out_last  <= k_is_last;
    end
  end

  // Shuffle list of local LED offsets. An entry not yet written this
  // request reads as its own address, which is the identity ordering.
  assign addr_a = cmd.out_rd ? k : i;

  always_ff @(posedge clk) begin
    if (cmd.swap_rd || cmd.out_rd) begin
      rd_a <= vld[addr_a] ? mem[addr_a] : addr_a;
      rd_b <= vld[j] ? mem[j] : j;
    end
    if (cmd.wr_i) begin
      mem[i] <= rd_b;
    end else if (cmd.wr_j) begin
      mem[j] <= rd_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < NUM_SEC; s++) begin
        slc[s] <= '0;
      end
    end else begin
      if (cmd.load) begin
        vld <= '0;
      end else if (cmd.wr_i) begin
        vld[i] <= 1'b1;
      end else if (cmd.wr_j) begin
        vld[j] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        if (k_is_last) begin
          slc[sec] <= color[OUT_CW-1:0];
        end
      end else if (cmd.out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {7'd0, out_color, out_lit, out_led};

  `TSPS_ASSERT_SAME(a_color_range, clk, rst, cmd.pass_step, DIV_W'(color) < COLOR_DIV)
  `TSPS_ASSERT_NEXT(a_swap_in_range, clk, rst, cmd.j_set, j <= i)
  `TSPS_ASSERT_SAME(a_out_free, clk, rst, cmd.out_load, !out_valid)

endmodule

/* hw/rtl/tix_section_pattern_shuffle.sv */
// An accepted request runs the color remainder and the color conflict pass, then one
// shuffle step per LED but the first, then gives its LED results one at a time, each
// held until the output side takes it. A request holds the block until its last
// result is taken; each shuffle step runs the remainder unit, then swaps entries i, j.
// A request whose count exceeds the section size ends with no result.
// Synchronous reset clears the stored section colors to zero and empties the output.
module tix_section_pattern_shuffle
  import tsps_pkg::*;
#(
  parameter int PALETTE_SIZE = 8
)
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // section, digit_count, color_rand, shuffle_rand_1 .. shuffle_rand_8, zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // led_index, lit, color_index, zero pad
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tlast
);

  tsps_cmd_t  cmd;
  tsps_stat_t stat;

  tsps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsps_dp #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* tb/tix_section_pattern_shuffle_tb.sv */
`timescale 1ns / 1ps

module tix_section_pattern_shuffle_tb
  import tsps_pkg::*;
();

  localparam int PALETTE = 8;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_REQUESTS = 280;

  typedef struct {
    logic [SEC_W-1:0]  sec;
    logic [CNT_W-1:0]  cnt;
    logic [BYTE_W-1:0] color_byte;
    logic [BYTE_W-1:0] swap_byte [NUM_RAND];
  } pattern_req_t;

  typedef struct packed {
    logic [LED_W-1:0]  led;
    logic              lit;
    logic [OUT_CW-1:0] color;
    logic              last;
  } led_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  // Last color given to each section, as the block should hold it.
  logic [OUT_CW-1:0] sec_color [NUM_SEC];
  led_result_t       led_queue [$];

  int errors = 0;
  int requests_sent = 0;
  int oversize_sent = 0;
  int results_seen = 0;
  int lit_seen = 0;
  int wraps_seen = 0;
  int idle_pct = 14;
  int stall_count = 0;

  tix_section_pattern_shuffle #(
    .PALETTE_SIZE(PALETTE)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int leds_in(int sec);
    case (sec)
      0: return 9;
      1: return 6;
      2: return 9;
      default: return 3;
    endcase
  endfunction

  function automatic int first_led(int sec);
    case (sec)
      0: return 0;
      1: return 9;
      2: return 15;
      default: return 24;
    endcase
  endfunction

  // A negative fill gives random shuffle bytes.
  function automatic pattern_req_t build_req(int sec, int cnt, logic [BYTE_W-1:0] color_byte,
                                             int fill);
    pattern_req_t r;
    r.sec = sec[SEC_W-1:0];
    r.cnt = cnt[CNT_W-1:0];
    r.color_byte = color_byte;
    for (int n = 0; n < NUM_RAND; n++) begin
      r.swap_byte[n] = (fill < 0) ? BYTE_W'($urandom_range(255)) : fill[BYTE_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH %s: got %0d, wanted %0d (result %0d)", field, got, want, results_seen);
    errors++;
  endtask

  // Works out the LED order and color for one accepted request.
  task automatic predict_section(pattern_req_t r);
    int size;
    int color;
    int j;
    logic [LED_W-1:0] order [LIST_DEPTH];
    logic [LED_W-1:0] held;
    led_result_t res;
    size = leds_in(r.sec);
    color = r.color_byte % PALETTE;
    for (int k = 0; k <= r.sec; k++) begin
      if (color[OUT_CW-1:0] == sec_color[k]) begin
        color++;
        if (color >= PALETTE) begin
          color = 0;
          wraps_seen++;
        end
      end
    end
    if (r.cnt > size) begin
      oversize_sent++;
      return;
    end
    for (int k = 0; k < size; k++) order[k] = LED_W'(first_led(r.sec) + k);
    for (int i = size - 1; i > 0; i--) begin
      j = r.swap_byte[size - i - 1] % (i + 1);
      held = order[i];
      order[i] = order[j];
      order[j] = held;
    end
    for (int k = 0; k < size; k++) begin
      res.led = order[k];
      res.lit = (k < r.cnt);
      res.color = color[OUT_CW-1:0];
      res.last = (k == size - 1);
      led_queue.push_back(res);
    end
    sec_color[r.sec] = color[OUT_CW-1:0];
  endtask

  task automatic send_request(pattern_req_t r);
    logic [IN_W-1:0] word;
    word = '0;
    word[SEC_W-1:0] = r.sec;
    word[SEC_W +: CNT_W] = r.cnt;
    word[SEC_W+CNT_W +: BYTE_W] = r.color_byte;
    for (int n = 0; n < NUM_RAND; n++) begin
      word[SEC_W+CNT_W+BYTE_W*(n+1) +: BYTE_W] = r.swap_byte[n];
    end
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    predict_section(r);
  endtask

  // Empty and full counts on every section, with all-zero and all-one bytes.
  task automatic test_extremes();
    for (int sec = 0; sec < NUM_SEC; sec++) begin
      send_request(build_req(sec, 0, 8'h00, 0));
      send_request(build_req(sec, leds_in(sec), 8'hFF, 255));
    end
  endtask

  // A count above the section size gives nothing and leaves the color alone.
  task automatic test_oversize();
    for (int sec = 0; sec < 3; sec++) begin
      send_request(build_req(sec, leds_in(sec) + 1, 8'($urandom_range(255)), -1));
    end
    send_request(build_req(3, 15, 8'hFF, 255));
    send_request(build_req(3, 2, 8'h00, -1));
  endtask

  // Color 7 twice on section 0 forces a wrap to 0; the following requests
  // start from the color of section 0 so the pass bumps more than once.
  task automatic test_color_chain();
    send_request(build_req(0, 5, 8'h07, -1));
    send_request(build_req(0, 9, 8'h07, -1));
    for (int sec = 1; sec < NUM_SEC; sec++) begin
      send_request(build_req(sec, sec, {5'd0, sec_color[0]}, -1));
    end
  endtask

  task automatic test_random();
    int done;
    int sec;
    int size;
    int cnt;
    logic [BYTE_W-1:0] color_byte;
    done = 0;
    while (done < RANDOM_REQUESTS) begin
      idle_pct = (done >= 100 && done < 160) ? 0 : 14;
      sec = $urandom_range(NUM_SEC - 1);
      size = leds_in(sec);
      if ($urandom_range(7) == 0) begin
        cnt = $urandom_range(15, size + 1);
      end else begin
        cnt = $urandom_range(size, 0);
      end
      if ($urandom_range(3) == 0) begin
        color_byte = {5'($urandom_range(31)), sec_color[$urandom_range(sec)]};
      end else begin
        color_byte = 8'($urandom_range(255));
      end
      send_request(build_req(sec, cnt, color_byte, -1));
      done++;
    end
    idle_pct = 14;
  endtask

  task automatic finish_run();
    s_tvalid <= 1'b0;
    while (led_queue.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("Sent %0d requests (%0d with an oversize count), checked %0d LED results, %0d lit.",
             requests_sent, oversize_sent, results_seen, lit_seen);
    $display("The color pass wrapped %0d times across all four sections.", wraps_seen);
    if (errors == 0 && led_queue.size() == 0) begin
      $display("tix_section_pattern_shuffle verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, led_queue.size());
      $display("tix_section_pattern_shuffle verification failed");
    end
    $finish;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    led_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (led_queue.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata, 0);
      end else begin
        want = led_queue.pop_front();
        if (m_tdata[LED_W-1:0] != want.led) begin
          report_mismatch("led_index", m_tdata[LED_W-1:0], want.led);
        end
        if (m_tdata[LED_W] != want.lit) report_mismatch("lit", m_tdata[LED_W], want.lit);
        if (m_tdata[LED_W+1 +: OUT_CW] != want.color) begin
          report_mismatch("color_index", m_tdata[LED_W+1 +: OUT_CW], want.color);
        end
        if (m_tlast != want.last) report_mismatch("last", m_tlast, want.last);
        if (m_tdata[LED_W]) lit_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
    end
    if (stall_count == STALL_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", STALL_LIMIT);
      $display("tix_section_pattern_shuffle verification failed");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < NUM_SEC; k++) sec_color[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_oversize();
    test_color_chain();
    test_random();
    finish_run();
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/tsps_pkg.sv
hw/rtl/tsps_mod.sv
hw/rtl/tsps_ctrl.sv
hw/rtl/tsps_dp.sv
hw/rtl/tix_section_pattern_shuffle.sv
tb/tix_section_pattern_shuffle_tb.sv
